### sv/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held
`define PLD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pld3d check failed");

// Clocked check that also runs during reset
`define PLD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pld3d reset check failed");

`endif

### sv/pld3d_pkg.sv
// Widths, constants and pipeline types of the point to line distance unit.
package pld3d_pkg;

    // Field widths
    localparam int COORD_W  = 24;
    localparam int DIST_W   = 25;
    localparam int FRAC_W   = 32;
    localparam int FRAC_FB  = 16;
    localparam int IN_W     = 9 * COORD_W;
    localparam int OUT_USED = DIST_W + 3 * COORD_W + FRAC_W;
    localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;
    localparam int NEAR_LSB = DIST_W;
    localparam int FRAC_LSB = DIST_W + 3 * COORD_W;

    // Datapath widths
    localparam int DIFF_W  = COORD_W + 1;           // P2-P1, P-P1
    localparam int MAG_W   = COORD_W;               // |A_i|
    localparam int PROD_W  = 2 * DIFF_W;            // 25x25 signed product
    localparam int T_W     = 50;                    // |A|^2
    localparam int DOT_W   = 51;                    // dot(D, A), signed
    localparam int CROSS_W = 51;                    // cross term, signed
    localparam int CMAG_W  = 49;                    // |cross term|
    localparam int CLO_W   = 25;
    localparam int CHI_W   = CMAG_W - CLO_W;
    localparam int DM_W    = 50;                    // |dot|
    localparam int DLO_W   = 25;
    localparam int DHI_W   = DM_W - DLO_W;
    localparam int Q_W     = 100;                   // |D x A|^2
    localparam int N_W     = DM_W + MAG_W;          // |dot|*|A_i|

    // Iterative units
    localparam int SQ_RW    = 104;                  // root residual, signed
    localparam int SQ_WW    = 78;                   // (2d-1)*t, signed
    localparam int SQ_STEPS = DIST_W;
    localparam int FRQ_W    = FRAC_W - 1;           // fraction quotient bits
    localparam int FR_NW    = 68;                   // fraction numerator
    localparam int FR_CW    = T_W + 1 + FRQ_W + 1;  // compare width
    localparam int NRQ_W    = 26;                   // offset quotient bits
    localparam int NR_NW    = N_W + 2;              // offset numerator
    localparam int NR_CW    = T_W + 1 + NRQ_W;
    localparam int NR_SUM_W = NRQ_W + 2;
    localparam int NIT      = FRQ_W;                // iteration stages
    localparam int NST      = NIT + 9;              // pipeline stages in total

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [FRAC_W-1:0]  FRAC_MAX  = {1'b0, {(FRAC_W-1){1'b1}}};
    localparam logic signed [FRAC_W-1:0]  FRAC_MIN  = {1'b1, {(FRAC_W-1){1'b0}}};

    // State carried through the root and divider stages
    typedef struct packed {
        logic signed [SQ_RW-1:0]      sq_r;
        logic signed [SQ_WW-1:0]      sq_w;
        logic [DIST_W-1:0]            sq_d;
        logic [T_W-1:0]               t;
        logic [FR_NW-1:0]             fr_r;
        logic [FRQ_W-1:0]             fr_q;
        logic                         fr_sat;
        logic [2:0][NR_NW-1:0]        nr_r;
        logic [2:0][NRQ_W-1:0]        nr_q;
        logic [2:0]                   nr_sat;
        logic [2:0]                   nr_neg;
        logic                         dot_neg;
        logic [2:0][COORD_W-1:0]      s;
        logic                         deg;
    } t_iter;

endpackage

### sv/point_line_distance_3d_unit.sv
// Point to line distance in 3D: pipelined cross/dot products, root and dividers.
//
//  channel   | dir | tdata (low bit up)                                  | tuser
//  s_axis    | in  | point_x/y/z, start_x/y/z, end_x/y/z (24b each)      | -
//  m_axis    | out | distance 25b, near_x/y/z 24b, fraction 32b, pad 7b  | degenerate
//
//  One request per cycle while the output is not stalled; 40 register stages lie
//  between an accepted request and its result on m_axis.
//  Depth is set by the bit-per-stage divider for fraction (31 stages).
//  Eight front stages hold differences, products, sums, partial products and seeds.
//  i_rst_n is synchronous active low and clears only the valid bits.
//  Each stage holds when its successor is full and stalled; bubbles collapse.
module point_line_distance_3d_unit
    import pld3d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // point_x, point_y, point_z, start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [IN_W-1:0]   i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // distance, near_x, near_y, near_z, fraction, zero pad
    output logic [OUT_W-1:0]  o_m_axis_tdata,
    // degenerate
    output logic [0:0]        o_m_axis_tuser
);

    logic [NST-1:0] r_v;
    logic [NST-1:0] n_v;
    logic [NST-1:0] en;

    logic signed [COORD_W-1:0] in_p [3];
    logic signed [COORD_W-1:0] in_s [3];
    logic signed [COORD_W-1:0] in_e [3];

    // stage 1
    logic signed [DIFF_W-1:0]  r_s1_a [3];
    logic signed [DIFF_W-1:0]  r_s1_d [3];
    logic [2:0][COORD_W-1:0]   r_s1_s;
    // stage 2
    logic signed [PROD_W-1:0]  r_s2_aa [3];
    logic signed [PROD_W-1:0]  r_s2_dd [3];
    logic signed [PROD_W-1:0]  r_s2_da [3];
    logic signed [PROD_W-1:0]  r_s2_x  [6];
    logic [MAG_W-1:0]          r_s2_amag [3];
    logic [2:0]                r_s2_aneg;
    logic [2:0][COORD_W-1:0]   r_s2_s;
    // stage 3
    logic [T_W-1:0]            r_s3_t;
    logic signed [DOT_W-1:0]   r_s3_dot;
    logic signed [CROSS_W-1:0] r_s3_c [3];
    logic [T_W-1:0]            r_s3_dd;
    logic [MAG_W-1:0]          r_s3_amag [3];
    logic [2:0]                r_s3_aneg;
    logic [2:0][COORD_W-1:0]   r_s3_s;
    // stage 4
    logic                      r_s4_deg;
    logic [CMAG_W-1:0]         r_s4_cmag [3];
    logic [DM_W-1:0]           r_s4_dm;
    logic                      r_s4_dneg;
    logic [T_W-1:0]            r_s4_t;
    logic [T_W-1:0]            r_s4_dd;
    logic [MAG_W-1:0]          r_s4_amag [3];
    logic [2:0]                r_s4_aneg;
    logic [2:0][COORD_W-1:0]   r_s4_s;
    // stage 5
    logic [2*CLO_W-1:0]        r_s5_cll [3];
    logic [CLO_W+CHI_W-1:0]    r_s5_clh [3];
    logic [2*CHI_W-1:0]        r_s5_chh [3];
    logic [DLO_W+MAG_W-1:0]    r_s5_nl  [3];
    logic [DHI_W+MAG_W-1:0]    r_s5_nh  [3];
    logic                      r_s5_deg;
    logic [DM_W-1:0]           r_s5_dm;
    logic                      r_s5_dneg;
    logic [T_W-1:0]            r_s5_t;
    logic [T_W-1:0]            r_s5_dd;
    logic [2:0]                r_s5_aneg;
    logic [2:0][COORD_W-1:0]   r_s5_s;
    // stage 6
    logic [Q_W-1:0]            r_s6_csq [3];
    logic [N_W-1:0]            r_s6_n   [3];
    logic                      r_s6_deg;
    logic [DM_W-1:0]           r_s6_dm;
    logic                      r_s6_dneg;
    logic [T_W-1:0]            r_s6_t;
    logic [T_W-1:0]            r_s6_dd;
    logic [2:0]                r_s6_aneg;
    logic [2:0][COORD_W-1:0]   r_s6_s;
    // stage 7
    logic [Q_W-1:0]            r_s7_q;
    logic [T_W-1:0]            r_s7_t;
    logic [N_W-1:0]            r_s7_n [3];
    logic                      r_s7_deg;
    logic [DM_W-1:0]           r_s7_dm;
    logic                      r_s7_dneg;
    logic [2:0]                r_s7_aneg;
    logic [2:0][COORD_W-1:0]   r_s7_s;

    // iteration stages
    t_iter                     n_init;
    logic [FR_NW-1:0]          init_fr_num;
    logic [NR_NW-1:0]          init_nr_num [3];
    t_iter                     r_it [0:NIT];

    // output stage
    logic [DIST_W-1:0]              r_o_dist;
    logic [2:0][COORD_W-1:0]        r_o_near;
    logic [FRAC_W-1:0]              r_o_frac;
    logic                           r_o_deg;
    logic [2:0][COORD_W-1:0]        n_o_near;
    logic [FRAC_W-1:0]              n_o_frac;
    logic signed [NR_SUM_W-1:0]     fin_off [3];
    logic signed [NR_SUM_W-1:0]     fin_sum [3];

    // Input unpack
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            in_p[k] = i_s_axis_tdata[k*COORD_W +: COORD_W];
            in_s[k] = i_s_axis_tdata[(3+k)*COORD_W +: COORD_W];
            in_e[k] = i_s_axis_tdata[(6+k)*COORD_W +: COORD_W];
        end
    end

    // Per-stage enables: a stage loads when empty or when its successor moves
    always_comb begin
        en[NST-1] = !r_v[NST-1] || i_m_axis_tready;
        for (int k = NST-2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign n_v = {r_v[NST-2:0], i_s_axis_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (en & n_v) | (~en & r_v);
        end
    end

    assign o_s_axis_tready = en[0];

    // Stage 1: differences A = P2-P1, D = P-P1
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int k = 0; k < 3; k++) begin
                r_s1_a[k] <= DIFF_W'(in_e[k]) - DIFF_W'(in_s[k]);
                r_s1_d[k] <= DIFF_W'(in_p[k]) - DIFF_W'(in_s[k]);
                r_s1_s[k] <= in_s[k];
            end
        end
    end

    // Stage 2: all 25x25 products
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int k = 0; k < 3; k++) begin
                r_s2_aa[k]   <= r_s1_a[k] * r_s1_a[k];
                r_s2_dd[k]   <= r_s1_d[k] * r_s1_d[k];
                r_s2_da[k]   <= r_s1_d[k] * r_s1_a[k];
                r_s2_amag[k] <= r_s1_a[k][DIFF_W-1] ? MAG_W'(-r_s1_a[k]) : MAG_W'(r_s1_a[k]);
                r_s2_aneg[k] <= r_s1_a[k][DIFF_W-1];
            end
            r_s2_x[0] <= r_s1_d[1] * r_s1_a[2];
            r_s2_x[1] <= r_s1_d[2] * r_s1_a[1];
            r_s2_x[2] <= r_s1_d[2] * r_s1_a[0];
            r_s2_x[3] <= r_s1_d[0] * r_s1_a[2];
            r_s2_x[4] <= r_s1_d[0] * r_s1_a[1];
            r_s2_x[5] <= r_s1_d[1] * r_s1_a[0];
            r_s2_s    <= r_s1_s;
        end
    end

    // Stage 3: |A|^2, dot, cross, |D|^2
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s3_t   <= T_W'($unsigned(r_s2_aa[0])) + T_W'($unsigned(r_s2_aa[1]))
                      + T_W'($unsigned(r_s2_aa[2]));
            r_s3_dd  <= T_W'($unsigned(r_s2_dd[0])) + T_W'($unsigned(r_s2_dd[1]))
                      + T_W'($unsigned(r_s2_dd[2]));
            r_s3_dot <= DOT_W'(r_s2_da[0]) + DOT_W'(r_s2_da[1]) + DOT_W'(r_s2_da[2]);
            r_s3_c[0] <= CROSS_W'(r_s2_x[0]) - CROSS_W'(r_s2_x[1]);
            r_s3_c[1] <= CROSS_W'(r_s2_x[2]) - CROSS_W'(r_s2_x[3]);
            r_s3_c[2] <= CROSS_W'(r_s2_x[4]) - CROSS_W'(r_s2_x[5]);
            r_s3_amag <= r_s2_amag;
            r_s3_aneg <= r_s2_aneg;
            r_s3_s    <= r_s2_s;
        end
    end

    // Stage 4: magnitudes, degenerate flag
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_s4_deg <= (r_s3_t == '0);
            for (int k = 0; k < 3; k++) begin
                r_s4_cmag[k] <= r_s3_c[k][CROSS_W-1] ? CMAG_W'(-r_s3_c[k])
                                                     : CMAG_W'(r_s3_c[k]);
            end
            r_s4_dm   <= r_s3_dot[DOT_W-1] ? DM_W'(-r_s3_dot) : DM_W'(r_s3_dot);
            r_s4_dneg <= r_s3_dot[DOT_W-1];
            r_s4_t    <= r_s3_t;
            r_s4_dd   <= r_s3_dd;
            r_s4_amag <= r_s3_amag;
            r_s4_aneg <= r_s3_aneg;
            r_s4_s    <= r_s3_s;
        end
    end

    // Stage 5: partial products of cross squares and |dot|*|A_i|
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            for (int k = 0; k < 3; k++) begin
                r_s5_cll[k] <= r_s4_cmag[k][CLO_W-1:0] * r_s4_cmag[k][CLO_W-1:0];
                r_s5_clh[k] <= r_s4_cmag[k][CLO_W-1:0] * r_s4_cmag[k][CMAG_W-1:CLO_W];
                r_s5_chh[k] <= r_s4_cmag[k][CMAG_W-1:CLO_W] * r_s4_cmag[k][CMAG_W-1:CLO_W];
                r_s5_nl[k]  <= r_s4_dm[DLO_W-1:0] * r_s4_amag[k];
                r_s5_nh[k]  <= r_s4_dm[DM_W-1:DLO_W] * r_s4_amag[k];
            end
            r_s5_deg  <= r_s4_deg;
            r_s5_dm   <= r_s4_dm;
            r_s5_dneg <= r_s4_dneg;
            r_s5_t    <= r_s4_t;
            r_s5_dd   <= r_s4_dd;
            r_s5_aneg <= r_s4_aneg;
            r_s5_s    <= r_s4_s;
        end
    end

    // Stage 6: recombine partial products
    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            for (int k = 0; k < 3; k++) begin
                r_s6_csq[k] <= (Q_W'(r_s5_chh[k]) << (2*CLO_W))
                             + (Q_W'(r_s5_clh[k]) << (CLO_W+1)) + Q_W'(r_s5_cll[k]);
                r_s6_n[k]   <= (N_W'(r_s5_nh[k]) << DLO_W) + N_W'(r_s5_nl[k]);
            end
            r_s6_deg  <= r_s5_deg;
            r_s6_dm   <= r_s5_dm;
            r_s6_dneg <= r_s5_dneg;
            r_s6_t    <= r_s5_t;
            r_s6_dd   <= r_s5_dd;
            r_s6_aneg <= r_s5_aneg;
            r_s6_s    <= r_s5_s;
        end
    end

    // Stage 7: root operand; a point line takes |D|^2 over one
    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_s7_q    <= r_s6_deg ? Q_W'(r_s6_dd) : r_s6_csq[0] + r_s6_csq[1] + r_s6_csq[2];
            r_s7_t    <= r_s6_deg ? T_W'(1) : r_s6_t;
            r_s7_n    <= r_s6_n;
            r_s7_deg  <= r_s6_deg;
            r_s7_dm   <= r_s6_dm;
            r_s7_dneg <= r_s6_dneg;
            r_s7_aneg <= r_s6_aneg;
            r_s7_s    <= r_s6_s;
        end
    end

    // Stage 8: seed root residual, rounded numerators, overflow checks
    always_comb begin
        n_init        = '0;
        n_init.sq_r   = $signed(SQ_RW'(r_s7_q) << 2) - $signed(SQ_RW'(r_s7_t));
        n_init.sq_w   = -$signed(SQ_WW'(r_s7_t));
        n_init.t      = r_s7_t;
        init_fr_num   = (FR_NW'(r_s7_dm) << (FRAC_FB+1)) + FR_NW'(r_s7_t);
        n_init.fr_r   = init_fr_num;
        n_init.fr_sat = FR_CW'(init_fr_num) >= (FR_CW'({r_s7_t, 1'b0}) << FRQ_W);
        for (int k = 0; k < 3; k++) begin
            init_nr_num[k]   = (NR_NW'(r_s7_n[k]) << 1) + NR_NW'(r_s7_t);
            n_init.nr_r[k]   = init_nr_num[k];
            n_init.nr_sat[k] = NR_CW'(init_nr_num[k]) >= (NR_CW'({r_s7_t, 1'b0}) << NRQ_W);
            n_init.nr_neg[k] = r_s7_dneg ^ r_s7_aneg[k];
        end
        n_init.dot_neg = r_s7_dneg;
        n_init.s       = r_s7_s;
        n_init.deg     = r_s7_deg;
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_it[0] <= n_init;
        end
    end

    // One quotient bit per stage for each divider, one root bit per stage
    for (genvar j = 0; j < NIT; j++) begin : g_it
        localparam int SB = (j < SQ_STEPS) ? SQ_STEPS - 1 - j : 0;
        localparam int FI = FRQ_W - 1 - j;
        localparam int NI = (j < NRQ_W) ? NRQ_W - 1 - j : 0;

        t_iter                   n_it;
        logic signed [SQ_RW-1:0] sq_x;
        logic signed [SQ_RW-1:0] sq_diff;
        logic [FR_CW-1:0]        fr_num;
        logic [FR_CW-1:0]        fr_den;
        logic [NR_CW-1:0]        nr_num [3];
        logic [NR_CW-1:0]        nr_den;

        always_comb begin
            n_it    = r_it[j];
            sq_x    = '0;
            sq_diff = '0;
            nr_den  = '0;
            for (int k = 0; k < 3; k++) begin
                nr_num[k] = '0;
            end
            // root: accept bit when (2c-1)^2 t still fits under 4q
            if (j < SQ_STEPS) begin
                sq_x    = ($signed(SQ_RW'(r_it[j].sq_w)) <<< (SB + 2))
                        + $signed(SQ_RW'(r_it[j].t) << (2*SB + 2));
                sq_diff = r_it[j].sq_r - sq_x;
                if (!sq_diff[SQ_RW-1]) begin
                    n_it.sq_r     = sq_diff;
                    n_it.sq_w     = r_it[j].sq_w + $signed(SQ_WW'(r_it[j].t) << (SB + 1));
                    n_it.sq_d[SB] = 1'b1;
                end
            end
            // fraction divider
            fr_num = FR_CW'(r_it[j].fr_r);
            fr_den = FR_CW'({r_it[j].t, 1'b0}) << FI;
            if (fr_num >= fr_den) begin
                n_it.fr_r     = FR_NW'(fr_num - fr_den);
                n_it.fr_q[FI] = 1'b1;
            end
            // offset dividers
            if (j < NRQ_W) begin
                nr_den = NR_CW'({r_it[j].t, 1'b0}) << NI;
                for (int k = 0; k < 3; k++) begin
                    nr_num[k] = NR_CW'(r_it[j].nr_r[k]);
                    if (nr_num[k] >= nr_den) begin
                        n_it.nr_r[k]     = NR_NW'(nr_num[k] - nr_den);
                        n_it.nr_q[k][NI] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[8+j]) begin
                r_it[j+1] <= n_it;
            end
        end
    end

    // Output stage: signs, offsets onto P1, saturation
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            fin_off[k] = r_it[NIT].nr_neg[k] ? -$signed(NR_SUM_W'(r_it[NIT].nr_q[k]))
                                             : $signed(NR_SUM_W'(r_it[NIT].nr_q[k]));
            fin_sum[k] = NR_SUM_W'($signed(r_it[NIT].s[k])) + fin_off[k];
            if (r_it[NIT].deg) begin
                n_o_near[k] = r_it[NIT].s[k];
            end else if (r_it[NIT].nr_sat[k]) begin
                n_o_near[k] = r_it[NIT].nr_neg[k] ? COORD_MIN : COORD_MAX;
            end else if (fin_sum[k] > NR_SUM_W'(COORD_MAX)) begin
                n_o_near[k] = COORD_MAX;
            end else if (fin_sum[k] < NR_SUM_W'(COORD_MIN)) begin
                n_o_near[k] = COORD_MIN;
            end else begin
                n_o_near[k] = COORD_W'(fin_sum[k]);
            end
        end
        if (r_it[NIT].deg) begin
            n_o_frac = '0;
        end else if (r_it[NIT].fr_sat) begin
            n_o_frac = r_it[NIT].dot_neg ? FRAC_MIN : FRAC_MAX;
        end else if (r_it[NIT].dot_neg) begin
            n_o_frac = -FRAC_W'(r_it[NIT].fr_q);
        end else begin
            n_o_frac = FRAC_W'(r_it[NIT].fr_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NST-1]) begin
            r_o_dist <= r_it[NIT].sq_d;
            r_o_near <= n_o_near;
            r_o_frac <= n_o_frac;
            r_o_deg  <= r_it[NIT].deg;
        end
    end

    assign o_m_axis_tvalid   = r_v[NST-1];
    assign o_m_axis_tdata    = {{(OUT_W-OUT_USED){1'b0}}, r_o_frac,
                                r_o_near[2], r_o_near[1], r_o_near[0], r_o_dist};
    assign o_m_axis_tuser[0] = r_o_deg;

endmodule

### sv/pld3d_chk.sv
// Port-level checker for the point to line distance unit, with its bind.
`include "assert_macros.svh"

module pld3d_chk
    import pld3d_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tready,
    input logic             i_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] i_m_axis_tdata,
    input logic [0:0]       i_m_axis_tuser
);

    // no result is shown right after reset
    `PLD_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_m_axis_tvalid)

    // a stalled result holds
    `PLD_ASSERT(a_out_hold, i_clk, i_rst_n,
        i_m_axis_tvalid && !i_m_axis_tready |=>
        i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tuser))

    // input side never blocks while the output side is free
    `PLD_ASSERT(a_no_block, i_clk, i_rst_n,
        !i_m_axis_tvalid || i_m_axis_tready |-> i_s_axis_tready)

    // a point line reports a zero fraction
    `PLD_ASSERT(a_deg_frac, i_clk, i_rst_n,
        i_m_axis_tvalid && i_m_axis_tuser[0] |->
        i_m_axis_tdata[FRAC_LSB +: FRAC_W] == '0)

endmodule

bind point_line_distance_3d_unit pld3d_chk u_pld3d_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser)
);

### tb/tb_top.sv
// Self-checking testbench for the 3D point to line distance unit.
module tb_top;
    import pld3d_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [0:0]        degenerate;
        logic [FRAC_W-1:0] fraction;
        logic [COORD_W-1:0] near_z;
        logic [COORD_W-1:0] near_y;
        logic [COORD_W-1:0] near_x;
        logic [DIST_W-1:0] distance;
    } t_answer;

    localparam int LAT = 40;
    localparam longint LIMIT = 2000000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [IN_W-1:0]   i_s_axis_tdata = '0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  o_m_axis_tdata;
    logic [0:0]        o_m_axis_tuser;

    t_answer answer_q[$];
    int      err_cnt = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    bit      hold_recv = 1'b0;
    longint  cyc = 0;

    point_line_distance_3d_unit dut (.*);

    // Clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Timeout
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cyc);
        err_cnt++;
    endtask

    // Round of |num| / den to nearest, ties away from zero
    function automatic logic [127:0] round_div(input logic [127:0] num, input logic [127:0] den);
        return (2 * num + den) / (2 * den);
    endfunction

    // Nearest integer to sqrt(s / t), ties up
    function automatic logic [24:0] root_ratio(input logic [127:0] s, input logic [127:0] t);
        logic [24:0]  d;
        logic [127:0] k;
        d = '0;
        for (int b = 24; b >= 0; b--) begin
            k = 2 * {103'd0, d | (25'd1 << b)} - 1;
            if (k * k * t <= 4 * s) d = d | (25'd1 << b);
        end
        return d;
    endfunction

    function automatic logic [127:0] mag(input longint v);
        return v < 0 ? 128'(-v) : 128'(v);
    endfunction

    // Expected distance, nearest point, fraction for one query
    function automatic t_answer predict_nearest(input logic [IN_W-1:0] req);
        longint  p[3], s[3], a[3], d[3], c[3], dot, fr, off, nr;
        logic [127:0] t, q, fm, om;
        t_answer r;
        for (int i = 0; i < 3; i++) begin
            p[i] = longint'($signed(req[i*COORD_W +: COORD_W]));
            s[i] = longint'($signed(req[(3+i)*COORD_W +: COORD_W]));
            a[i] = longint'($signed(req[(6+i)*COORD_W +: COORD_W])) - s[i];
            d[i] = p[i] - s[i];
        end
        t = 128'(a[0]*a[0] + a[1]*a[1] + a[2]*a[2]);
        r.near_x = s[0][23:0];
        r.near_y = s[1][23:0];
        r.near_z = s[2][23:0];
        r.fraction = '0;
        r.degenerate = (t == 0);
        if (t == 0) begin
            q = mag(d[0])*mag(d[0]) + mag(d[1])*mag(d[1]) + mag(d[2])*mag(d[2]);
            r.distance = root_ratio(q, 1);
        end else begin
            dot = d[0]*a[0] + d[1]*a[1] + d[2]*a[2];
            c[0] = d[1]*a[2] - d[2]*a[1];
            c[1] = d[2]*a[0] - d[0]*a[2];
            c[2] = d[0]*a[1] - d[1]*a[0];
            q = mag(c[0])*mag(c[0]) + mag(c[1])*mag(c[1]) + mag(c[2])*mag(c[2]);
            r.distance = root_ratio(q, t);
            fm = round_div(mag(dot) * 65536, t);
            if (fm > 128'h8000_0000) fm = 128'h8000_0000;
            fr = dot < 0 ? -longint'(fm) : longint'(fm);
            if (fr > 64'sh7FFF_FFFF) fr = 64'sh7FFF_FFFF;
            r.fraction = fr[31:0];
            for (int i = 0; i < 3; i++) begin
                om = round_div(mag(dot) * mag(a[i]), t);
                if (om > 128'h400_0000) om = 128'h400_0000;
                off = ((dot < 0) != (a[i] < 0)) ? -longint'(om) : longint'(om);
                nr = s[i] + off;
                if (nr > 8388607) nr = 8388607;
                if (nr < -8388608) nr = -8388608;
                case (i)
                    0: r.near_x = nr[23:0];
                    1: r.near_y = nr[23:0];
                    default: r.near_z = nr[23:0];
                endcase
            end
        end
        return r;
    endfunction

    // Receiver ready: random idling, or held off on request
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_recv) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_answer got, exp;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.distance = o_m_axis_tdata[DIST_W-1:0];
            got.near_x = o_m_axis_tdata[NEAR_LSB +: COORD_W];
            got.near_y = o_m_axis_tdata[NEAR_LSB + COORD_W +: COORD_W];
            got.near_z = o_m_axis_tdata[NEAR_LSB + 2*COORD_W +: COORD_W];
            got.fraction = o_m_axis_tdata[FRAC_LSB +: FRAC_W];
            got.degenerate = o_m_axis_tuser;
            if (answer_q.size() == 0) begin
                report("unexpected result", 64'(got.distance), 0);
            end else begin
                exp = answer_q.pop_front();
                if (got.distance != exp.distance)
                    report("distance", 64'(got.distance), 64'(exp.distance));
                if (got.near_x != exp.near_x) report("near_x", 64'(got.near_x), 64'(exp.near_x));
                if (got.near_y != exp.near_y) report("near_y", 64'(got.near_y), 64'(exp.near_y));
                if (got.near_z != exp.near_z) report("near_z", 64'(got.near_z), 64'(exp.near_z));
                if (got.fraction != exp.fraction)
                    report("fraction", 64'(got.fraction), 64'(exp.fraction));
                if (got.degenerate != exp.degenerate)
                    report("degenerate", 64'(got.degenerate), 64'(exp.degenerate));
            end
        end
    end

    // Send one request, with random leading idle cycles; valid stays up after
    // the accept so back-to-back requests need no gap
    task automatic send_query(input logic [IN_W-1:0] req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tdata  <= req;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        answer_q.push_back(predict_nearest(req));
    endtask

    function automatic logic [IN_W-1:0] pack9(input logic [23:0] v[9]);
        logic [IN_W-1:0] r;
        for (int i = 0; i < 9; i++) r[i*COORD_W +: COORD_W] = v[i];
        return r;
    endfunction

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(5))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return 24'($signed($urandom_range(2000)) - 1000);
            default: return 24'($urandom);
        endcase
    endfunction

    // Stop offering and wait until every expected result has come
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
    endtask

    // Extremes, degenerate lines, points on the line, saturation
    task automatic test_directed();
        logic [23:0] v[9];
        logic [23:0] ext[4];
        ext = '{COORD_MAX, COORD_MIN, 24'd0, 24'hFFFFFF};
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 9; i++) v[i] = ext[(k + i) % 4];
            send_query(pack9(v));
        end
        // degenerate: start equals end
        v = '{24'd256, 24'd512, 24'd768, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
        send_query(pack9(v));
        v = '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
              COORD_MIN, COORD_MIN, COORD_MIN};
        send_query(pack9(v));
        v = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
        send_query(pack9(v));
        // point on the line, halfway
        v = '{24'd128, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd256, 24'd0, 24'd0};
        send_query(pack9(v));
        // huge fraction: tiny segment, far point (saturates fraction and near)
        v = '{COORD_MAX, COORD_MAX, COORD_MAX, 24'd0, 24'd0, 24'd0, 24'd1, 24'd1, 24'd1};
        send_query(pack9(v));
        v = '{COORD_MIN, COORD_MAX, COORD_MIN, 24'd0, 24'd0, 24'd0, 24'd1, 24'hFFFFFF, 24'd0};
        send_query(pack9(v));
        // negative fraction
        v = '{-24'sd512, 24'd300, 24'd7, 24'd0, 24'd0, 24'd0, 24'd256, 24'd0, 24'd0};
        send_query(pack9(v));
        // point at start, point at end
        v = '{24'd5, 24'd6, 24'd7, 24'd5, 24'd6, 24'd7, 24'd50, 24'd60, 24'd70};
        send_query(pack9(v));
        v = '{24'd50, 24'd60, 24'd70, 24'd5, 24'd6, 24'd7, 24'd50, 24'd60, 24'd70};
        send_query(pack9(v));
        wait_drained();
    endtask

    // Random lines, many short segments and degenerate cases
    task automatic test_random(input int n);
        logic [23:0] v[9];
        for (int j = 0; j < n; j++) begin
            for (int i = 0; i < 9; i++) v[i] = rand_coord();
            case ($urandom_range(7))
                0: for (int i = 0; i < 3; i++) v[6+i] = v[3+i];
                1: for (int i = 0; i < 3; i++)
                       v[6+i] = v[3+i] + 24'($signed($urandom_range(8)) - 4);
                default: ;
            endcase
            send_query(pack9(v));
        end
    endtask

    // Receiver held off while the sender keeps offering
    task automatic test_backpressure();
        logic [23:0] v[9];
        hold_recv <= 1'b1;
        fork
            begin
                for (int j = 0; j < 80; j++) begin
                    for (int i = 0; i < 9; i++) v[i] = 24'($urandom);
                    send_query(pack9(v));
                end
            end
            begin
                repeat (300) @(posedge i_clk);
                hold_recv <= 1'b0;
            end
        join
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        send_idle_pct = 21;
        recv_idle_pct = 69;
        test_random(350);
        wait_drained();
        send_idle_pct = 69;
        recv_idle_pct = 21;
        test_random(350);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(320);
        wait_drained();
        repeat (LAT + 10) @(posedge i_clk);
        if (err_cnt == 0 && answer_q.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
